// ----- hw/rtl/etpw_pkg.sv -----
// etpw_pkg: shared types and constants for the exposure tone-map pixel writer.
// No dependencies; used by every module of the block.
`default_nettype none

package etpw_pkg;

    typedef enum logic {
        OP_DRAW = 1'b0,
        OP_READ = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_IMAGE_WIDTH   = 1'b0,
        REG_EXPOSURE_GAIN = 1'b1
    } reg_index_t;

    localparam int CHAN_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 24;
    localparam int WIDTH_W     = 9;
    localparam int FULL_ADDR_W = 17;
    localparam int APB_W       = 32;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 9'd256;
    localparam logic [CHAN_W-1:0]  GAIN_RESET  = 16'd0;
    localparam logic [12:0]        ONE_Q12     = 13'd4096;
    localparam logic [16:0]        ONE_Q16     = 17'h10000;

    typedef struct packed {
        logic                   wr;
        logic                   rd;
        logic [FULL_ADDR_W-1:0] addr;
        logic [WORD_W-1:0]      data;
    } mem_req_t;

    typedef struct packed {
        logic clearing;
    } store_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/etpw_lane.sv -----
// etpw_lane: four-stage tone-map pipeline for one colour channel.
// Depends on etpw_pkg; holds the exp table as an elaboration-time constant.
`default_nettype none

module etpw_lane #(
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [etpw_pkg::CHAN_W-1:0] chan,
    input  logic [etpw_pkg::CHAN_W-1:0] gain,
    output logic [etpw_pkg::BYTE_W-1:0] level
);

    localparam int FRAC_BITS  = 16 - EXP_TABLE_BITS;
    localparam int TABLE_LAST = 1 << EXP_TABLE_BITS;
    localparam int IDX_W      = EXP_TABLE_BITS + 1;
    localparam int MW         = 17 + FRAC_BITS;

    localparam logic [16:0] ONE_Q16_L = etpw_pkg::ONE_Q16;
    localparam logic [12:0] ONE_Q12_L = etpw_pkg::ONE_Q12;

    typedef logic [16:0] exp_tab_t [TABLE_LAST+1];

    function automatic exp_tab_t build_exp_tab();
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] ratio;
        logic [63:0] acc;
        exp_tab_t    tab;
        term = 64'h1_0000_0000;
        sum  = term;
        acc  = term;
        for (int n = 1; n <= 24; n++)
        begin
            term = (term >> (EXP_TABLE_BITS - 4)) / 64'(n);
            if (n[0])
            begin
                sum = (term > sum) ? 64'd0 : sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        ratio = sum;
        if (ratio >= 64'h1_0000_0000)
        begin
            ratio = 64'hFFFF_FFFF;
        end
        tab[0] = ONE_Q16_L;
        for (int k = 1; k <= TABLE_LAST; k++)
        begin
            acc    = (acc * ratio + 64'h8000_0000) >> 32;
            tab[k] = 17'((acc + 64'd32768) >> 16);
        end
        return tab;
    endfunction

    localparam exp_tab_t    EXP_TAB   = build_exp_tab();

    // stage A
    logic [31:0] prod_reg, prod_next;
    logic [12:0] clip_reg, clip_next;
    // stage B
    logic [16:0]          a_reg, a_next;
    logic [16:0]          diff_reg, diff_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [7:0]           zlev_reg, zlev_next;
    // stage C
    logic [16:0] d_reg, d_next;
    logic [7:0]  zlev2_reg;
    // stage D
    logic [7:0]  level_reg, level_next;

    logic [32:0]      psum;
    logic [20:0]      pq;
    logic [16:0]      p;
    logic [IDX_W-1:0] idx;
    logic [16:0]      ta, tb;
    logic [19:0]      zsum;
    logic [MW-1:0]    msum;
    logic [16:0]      y;
    logic [24:0]      ysum;

    always_comb
    begin
        clip_next = (chan > 16'(ONE_Q12_L)) ? ONE_Q12_L : chan[12:0];
        prod_next = 32'(chan) * 32'(gain);
    end

    always_comb
    begin
        psum = 33'(prod_reg) + 33'd2048;
        pq   = psum[32:12];
        p    = (pq > 21'(ONE_Q16_L)) ? ONE_Q16_L : pq[16:0];
        idx  = p[16:FRAC_BITS];
        frac_next = p[FRAC_BITS-1:0];
        if (32'(idx) >= TABLE_LAST)
        begin
            ta = EXP_TAB[TABLE_LAST];
            tb = ta;
        end
        else
        begin
            ta = EXP_TAB[idx];
            tb = EXP_TAB[idx + IDX_W'(1)];
        end
        a_next    = ta;
        diff_next = (ta >= tb) ? ta - tb : 17'd0;
        zsum      = 20'(clip_reg) * 20'd255 + 20'd2048;
        zlev_next = zsum[19:12];
    end

    always_comb
    begin
        msum   = MW'(diff_reg) * MW'(frac_reg) + MW'(1 << (FRAC_BITS - 1));
        d_next = a_reg - 17'(msum >> FRAC_BITS);
    end

    always_comb
    begin
        y          = ONE_Q16_L - d_reg;
        ysum       = 25'(y) * 25'd255 + 25'd32768;
        level_next = (gain == '0) ? zlev2_reg : ysum[23:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            clip_reg  <= clip_next;
            a_reg     <= a_next;
            diff_reg  <= diff_next;
            frac_reg  <= frac_next;
            zlev_reg  <= zlev_next;
            d_reg     <= d_next;
            zlev2_reg <= zlev_reg;
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/etpw_frame_store.sv -----
// etpw_frame_store: single-port framebuffer with registered read and a
// clearing sweep after reset. Depends on etpw_pkg.
`default_nettype none

module etpw_frame_store #(
    parameter int DEPTH = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  etpw_pkg::mem_req_t          req,
    output logic [etpw_pkg::WORD_W-1:0] rdata,
    output etpw_pkg::store_status_t     status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [etpw_pkg::WORD_W-1:0] mem [DEPTH];
    logic [etpw_pkg::WORD_W-1:0] rdata_reg;
    logic [AW-1:0]               clr_reg, clr_next;
    logic                        clearing_reg, clearing_next;
    logic [AW-1:0]               idx;

    assign idx = AW'(req.addr);

    always_comb
    begin
        clr_next      = clr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            if (32'(clr_reg) == DEPTH - 1)
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_next = clr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_reg      <= clr_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_reg] <= '0;
        end
        else if (req.wr)
        begin
            mem[idx] <= req.data;
        end
        if (req.rd)
        begin
            rdata_reg <= mem[idx];
        end
    end

    assign rdata           = rdata_reg;
    assign status.clearing = clearing_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/exposure_tonemap_pixel_writer_core.sv -----
// exposure_tonemap_pixel_writer_core: top level; config registers, address
// path, pipeline control. Depends on etpw_pkg, etpw_lane, etpw_frame_store.
//
//  channel  signals                               direction  accepted when
//  pix      pix_valid pix_stall + input fields    in         pix_valid & !pix_stall
//  res      res_valid res_stall + result fields   out        res_valid & !res_stall
//  apb      psel penable pwrite paddr pwdata ...  in         psel & penable & pwrite
//
// One item per cycle while pix_stall is low; res_valid is the stage-E valid bit.
// Stages A to D compute the colour; the framebuffer port is used in stage D
// (draw write or read) and its read data lands in stage E.
// After reset a clearing sweep over all MAX_WIDTH*MAX_HEIGHT entries zeroes the
// framebuffer; pix_stall is high for its duration.
// A stalled result freezes the whole pipeline, framebuffer port included.
`default_nettype none

module exposure_tonemap_pixel_writer_core #(
    parameter int MAX_WIDTH      = 256,
    parameter int MAX_HEIGHT     = 256,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  logic                          opcode,
    input  logic [7:0]                    pos_x,
    input  logic [7:0]                    pos_y,
    input  logic [etpw_pkg::CHAN_W-1:0]   red_in,
    input  logic [etpw_pkg::CHAN_W-1:0]   green_in,
    input  logic [etpw_pkg::CHAN_W-1:0]   blue_in,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [etpw_pkg::WORD_W-1:0]   pixel_word,
    output logic                          in_range,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [etpw_pkg::APB_W-1:0]    pwdata,
    output logic [etpw_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int FAW   = etpw_pkg::FULL_ADDR_W;

    logic [etpw_pkg::WIDTH_W-1:0] image_width_reg;
    logic [etpw_pkg::CHAN_W-1:0]  gain_reg;

    logic en;
    logic accept;

    logic va_reg, vb_reg, vc_reg, vd_reg, ve_reg;

    etpw_pkg::opcode_t op_a_reg, op_b_reg, op_c_reg, op_d_reg, op_e_reg;
    logic [7:0]        x_a_reg, y_a_reg;
    logic [FAW-1:0]    addr_a_reg, addr_b_reg, addr_c_reg, addr_d_reg;
    logic [FAW-1:0]    addr_next;
    logic              inside_next;
    logic              inside_b_reg, inside_c_reg, inside_d_reg, inside_e_reg;
    logic [etpw_pkg::WORD_W-1:0] word_d, word_e_reg, rdata;

    logic [etpw_pkg::BYTE_W-1:0] red_lvl, green_lvl, blue_lvl;

    etpw_pkg::mem_req_t      mem_req;
    etpw_pkg::store_status_t status;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= etpw_pkg::WIDTH_RESET;
            gain_reg        <= etpw_pkg::GAIN_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (etpw_pkg::reg_index_t'(paddr[2]))
                etpw_pkg::REG_IMAGE_WIDTH:   image_width_reg <= pwdata[etpw_pkg::WIDTH_W-1:0];
                etpw_pkg::REG_EXPOSURE_GAIN: gain_reg        <= pwdata[etpw_pkg::CHAN_W-1:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (etpw_pkg::reg_index_t'(paddr[2]))
            etpw_pkg::REG_IMAGE_WIDTH:   prdata = 32'(image_width_reg);
            etpw_pkg::REG_EXPOSURE_GAIN: prdata = 32'(gain_reg);
            default:                     prdata = '0;
        endcase
    end

    // pipeline control
    assign en        = !(ve_reg && res_stall);
    assign pix_stall = !en || status.clearing;
    assign accept    = pix_valid && !pix_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= accept;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    // address path
    always_comb
    begin
        addr_next   = FAW'(pos_x) + FAW'(image_width_reg) * FAW'(pos_y);
        inside_next = (9'(x_a_reg) < image_width_reg) && (32'(x_a_reg) < MAX_WIDTH)
                      && (32'(y_a_reg) < MAX_HEIGHT) && (32'(addr_a_reg) < DEPTH);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_a_reg     <= etpw_pkg::opcode_t'(opcode);
            x_a_reg      <= pos_x;
            y_a_reg      <= pos_y;
            addr_a_reg   <= addr_next;
            op_b_reg     <= op_a_reg;
            addr_b_reg   <= addr_a_reg;
            inside_b_reg <= inside_next;
            op_c_reg     <= op_b_reg;
            addr_c_reg   <= addr_b_reg;
            inside_c_reg <= inside_b_reg;
            op_d_reg     <= op_c_reg;
            addr_d_reg   <= addr_c_reg;
            inside_d_reg <= inside_c_reg;
            op_e_reg     <= op_d_reg;
            inside_e_reg <= inside_d_reg;
            word_e_reg   <= word_d;
        end
    end

    etpw_lane #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_lane_red (
        .clk   (clk),
        .en    (en),
        .chan  (red_in),
        .gain  (gain_reg),
        .level (red_lvl)
    );

    etpw_lane #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_lane_green (
        .clk   (clk),
        .en    (en),
        .chan  (green_in),
        .gain  (gain_reg),
        .level (green_lvl)
    );

    etpw_lane #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_lane_blue (
        .clk   (clk),
        .en    (en),
        .chan  (blue_in),
        .gain  (gain_reg),
        .level (blue_lvl)
    );

    assign word_d = {red_lvl, green_lvl, blue_lvl};

    // all pipeline framebuffer accesses happen in stage D, in item order
    always_comb
    begin
        mem_req.wr   = en && vd_reg && (op_d_reg == etpw_pkg::OP_DRAW) && inside_d_reg;
        mem_req.rd   = en;
        mem_req.addr = addr_d_reg;
        mem_req.data = word_d;
    end

    etpw_frame_store #(.DEPTH(DEPTH)) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mem_req),
        .rdata  (rdata),
        .status (status)
    );

    assign res_valid  = ve_reg;
    assign in_range   = inside_e_reg;
    assign pixel_word = (op_e_reg == etpw_pkg::OP_DRAW) ? word_e_reg
                      : (inside_e_reg ? rdata : '0);

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall) |=> va_reg)
        else $error("accepted item did not enter the pipeline");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !status.clearing)
        else $error("result present during framebuffer clearing");

    a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr |-> !status.clearing)
        else $error("draw write collides with clearing sweep");

endmodule

`default_nettype wire

// ----- dv/exposure_tonemap_pixel_writer_core_tb.sv -----
// Self-checking testbench for exposure_tonemap_pixel_writer_core: draw and read items
// are compared with a tone-map and framebuffer predictor held in a scoreboard class.
// Depends on etpw_pkg and the core RTL only.
`timescale 1ns / 1ps

module exposure_tonemap_pixel_writer_core_tb;

    localparam int EXP_BITS     = 8;
    localparam int FRAC_W       = 16 - EXP_BITS;
    localparam int LUT_LAST     = 1 << EXP_BITS;
    localparam int STORE_DEPTH  = 65536;
    localparam int PIPE_LATENCY = 5;
    localparam int STALL_LIMIT  = 300000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 190;

    typedef struct {
        bit [etpw_pkg::WORD_W-1:0] word;
        bit                        in_bounds;
    } pixel_result_t;

    class tonemap_scoreboard;
        bit [etpw_pkg::WIDTH_W-1:0] image_width;
        bit [etpw_pkg::CHAN_W-1:0]  exposure;
        int unsigned                exp_lut [LUT_LAST+1];
        bit [etpw_pkg::WORD_W-1:0]  frame [STORE_DEPTH];
        pixel_result_t              expected_pixels [$];
        int                         errors;

        function new();
            longint unsigned term;
            longint unsigned sum;
            longint unsigned ratio;
            longint unsigned acc;
            image_width = etpw_pkg::WIDTH_RESET;
            exposure    = etpw_pkg::GAIN_RESET;
            errors      = 0;
            foreach (frame[i]) frame[i] = '0;
            term = 64'h1_0000_0000;
            sum  = term;
            acc  = term;
            // exp(-step) by truncated series, step = 2^(4-EXP_BITS)
            for (int n = 1; n <= 24; n++) begin
                term = (term >> (EXP_BITS - 4)) / n;
                if (n % 2 == 1)
                    sum = (term > sum) ? 64'd0 : sum - term;
                else
                    sum = sum + term;
            end
            ratio = (sum >= 64'h1_0000_0000) ? 64'hFFFF_FFFF : sum;
            exp_lut[0] = 65536;
            for (int k = 1; k <= LUT_LAST; k++) begin
                acc = (acc * ratio + 64'h8000_0000) >> 32;
                exp_lut[k] = int'((acc + 64'd32768) >> 16);
            end
        endfunction

        function void set_register(etpw_pkg::reg_index_t idx,
                                   bit [etpw_pkg::APB_W-1:0] value);
            case (idx)
                etpw_pkg::REG_IMAGE_WIDTH:
                    image_width = value[etpw_pkg::WIDTH_W-1:0];
                etpw_pkg::REG_EXPOSURE_GAIN:
                    exposure    = value[etpw_pkg::CHAN_W-1:0];
            endcase
        endfunction

        function bit [etpw_pkg::BYTE_W-1:0] tone(bit [etpw_pkg::CHAN_W-1:0] c);
            longint unsigned cw;
            longint unsigned p;
            int unsigned idx, f, d, a, b, diff, y, v;
            if (exposure == 0) begin
                v = (c > 4096) ? 4096 : c;
                return 8'((v * 255 + 2048) >> 12);
            end
            cw = c;
            p  = (cw * exposure + 64'd2048) >> 12;
            if (p > 65536)
                p = 65536;
            idx = int'(p >> FRAC_W);
            f   = int'(p & ((64'd1 << FRAC_W) - 1));
            if (idx >= LUT_LAST) begin
                d = exp_lut[LUT_LAST];
            end
            else begin
                a    = exp_lut[idx];
                b    = exp_lut[idx+1];
                diff = (a >= b) ? a - b : 0;
                d    = a - ((diff * f + (1 << (FRAC_W - 1))) >> FRAC_W);
            end
            y = (d > 65536) ? 0 : 65536 - d;
            return 8'((y * 255 + 32768) >> 16);
        endfunction

        function void note_pixel(etpw_pkg::opcode_t op, bit [7:0] x, bit [7:0] y,
                                 bit [etpw_pkg::CHAN_W-1:0] r,
                                 bit [etpw_pkg::CHAN_W-1:0] g,
                                 bit [etpw_pkg::CHAN_W-1:0] b);
            int unsigned   addr;
            pixel_result_t res;
            addr          = x + image_width * y;
            res.in_bounds = (x < image_width) && (addr < STORE_DEPTH);
            if (op == etpw_pkg::OP_DRAW) begin
                res.word = {tone(r), tone(g), tone(b)};
                if (res.in_bounds)
                    frame[addr] = res.word;
            end
            else begin
                res.word = res.in_bounds ? frame[addr] : '0;
            end
            expected_pixels.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_pixel(bit [etpw_pkg::WORD_W-1:0] word, bit in_bounds);
            pixel_result_t exp_res;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %06h", word));
                return;
            end
            exp_res = expected_pixels.pop_front();
            if (word !== exp_res.word)
                report_mismatch($sformatf("pixel_word %06h, predicted %06h",
                                          word, exp_res.word));
            if (in_bounds !== exp_res.in_bounds)
                report_mismatch($sformatf("in_range %0b, predicted %0b",
                                          in_bounds, exp_res.in_bounds));
        endtask

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        pix_valid;
    logic                        pix_stall;
    logic                        opcode;
    logic [7:0]                  pos_x;
    logic [7:0]                  pos_y;
    logic [etpw_pkg::CHAN_W-1:0] red_in;
    logic [etpw_pkg::CHAN_W-1:0] green_in;
    logic [etpw_pkg::CHAN_W-1:0] blue_in;
    logic                        res_valid;
    logic                        res_stall;
    logic [etpw_pkg::WORD_W-1:0] pixel_word;
    logic                        in_range;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [2:0]                  paddr;
    logic [etpw_pkg::APB_W-1:0]  pwdata;
    logic [etpw_pkg::APB_W-1:0]  prdata;
    logic                        pready;

    tonemap_scoreboard sb;
    int                send_idle_pct;
    int                stall_pct;
    bit [15:0]         drawn_coords [$];

    exposure_tonemap_pixel_writer_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .opcode     (opcode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .pixel_word (pixel_word),
        .in_range   (in_range),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic send_pixel(etpw_pkg::opcode_t op, bit [7:0] x, bit [7:0] y,
                              bit [etpw_pkg::CHAN_W-1:0] r,
                              bit [etpw_pkg::CHAN_W-1:0] g,
                              bit [etpw_pkg::CHAN_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        opcode    <= op;
        pos_x     <= x;
        pos_y     <= y;
        red_in    <= r;
        green_in  <= g;
        blue_in   <= b;
        do
            @(posedge clk);
        while (!(pix_valid === 1'b1 && pix_stall === 1'b0));
        sb.note_pixel(op, x, y, r, g, b);
    endtask

    task automatic wait_drained();
        pix_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY * 2) @(posedge clk);
    endtask

    task automatic apb_write(etpw_pkg::reg_index_t idx, bit [etpw_pkg::APB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(idx, value);
    endtask

    function automatic bit [etpw_pkg::CHAN_W-1:0] rand_chan();
        case ($urandom_range(4))
            0, 1:    return 16'($urandom_range(16'hFFFF));
            2:       return 16'($urandom_range(4200));
            3: begin
                case ($urandom_range(3))
                    0:       return 16'd0;
                    1:       return 16'd4095;
                    2:       return 16'd4096;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom_range(1024));
        endcase
    endfunction

    task automatic random_pixel();
        etpw_pkg::opcode_t op;
        bit [7:0]          x;
        bit [7:0]          y;
        bit [15:0]         xy;
        int                span;
        op   = ($urandom_range(99) < 30) ? etpw_pkg::OP_READ : etpw_pkg::OP_DRAW;
        span = (sb.image_width == 0 || sb.image_width > 256) ? 256 : sb.image_width;
        if (op == etpw_pkg::OP_READ && drawn_coords.size() > 0 &&
            $urandom_range(99) < 75) begin
            // read back a recently drawn pixel
            xy = drawn_coords[$urandom_range(drawn_coords.size() - 1)];
            x  = xy[15:8];
            y  = xy[7:0];
        end
        else begin
            x = ($urandom_range(99) < 85) ? 8'($urandom_range(span - 1))
                                          : 8'($urandom_range(255));
            y = 8'($urandom_range(255));
        end
        if (op == etpw_pkg::OP_DRAW) begin
            drawn_coords.push_back({x, y});
            if (drawn_coords.size() > 64)
                void'(drawn_coords.pop_front());
        end
        send_pixel(op, x, y, rand_chan(), rand_chan(), rand_chan());
    endtask

    // result side: random stall, check every accepted item
    initial begin
        forever begin
            @(posedge clk);
            if (res_valid === 1'b1 && res_stall === 1'b0)
                sb.check_pixel(pixel_word, in_range);
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge clk);
            if ((pix_valid === 1'b1 && pix_stall === 1'b0) ||
                (res_valid === 1'b1 && res_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        bit [8:0]  phase_width [PHASES];
        bit [15:0] phase_gain  [PHASES];
        bit [15:0] gain;
        sb            = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        phase_width   = '{9'd256, 9'd1, 9'd255, 9'd100, 9'd0, 9'd511, 9'd37, 9'd256};
        phase_gain    = '{16'd0, 16'd4096, 16'hFFFF, 16'd0, 16'd0, 16'h2000, 16'd0, 16'd1};
        rst_n     <= 1'b0;
        pix_valid <= 1'b0;
        opcode    <= etpw_pkg::OP_DRAW;
        pos_x     <= '0;
        pos_y     <= '0;
        red_in    <= '0;
        green_in  <= '0;
        blue_in   <= '0;
        res_stall <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: plain clamp, width 256
        send_pixel(etpw_pkg::OP_READ, 8'd5, 8'd5, 16'd0, 16'd0, 16'd0);
        send_pixel(etpw_pkg::OP_DRAW, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
        send_pixel(etpw_pkg::OP_DRAW, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(etpw_pkg::OP_DRAW, 8'd17, 8'd3, 16'd4096, 16'd2048, 16'd1);
        send_pixel(etpw_pkg::OP_DRAW, 8'd18, 8'd3, 16'd4095, 16'd4097, 16'h8000);
        send_pixel(etpw_pkg::OP_READ, 8'd0, 8'd0, 16'hFFFF, 16'h0, 16'h0);
        send_pixel(etpw_pkg::OP_READ, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0);
        send_pixel(etpw_pkg::OP_READ, 8'd17, 8'd3, 16'd0, 16'd0, 16'd0);
        send_pixel(etpw_pkg::OP_READ, 8'd18, 8'd3, 16'd0, 16'd0, 16'd0);
        wait_drained();
        // narrow image: draw and read beyond the row end
        apb_write(etpw_pkg::REG_IMAGE_WIDTH, 32'd100);
        send_pixel(etpw_pkg::OP_DRAW, 8'd99, 8'd0, 16'd1000, 16'd2000, 16'd3000);
        send_pixel(etpw_pkg::OP_DRAW, 8'd100, 8'd0, 16'd4096, 16'd0, 16'd4096);
        send_pixel(etpw_pkg::OP_READ, 8'd150, 8'd0, 16'd0, 16'd0, 16'd0);
        send_pixel(etpw_pkg::OP_DRAW, 8'd99, 8'd255, 16'd300, 16'd600, 16'd900);
        send_pixel(etpw_pkg::OP_READ, 8'd99, 8'd255, 16'd0, 16'd0, 16'd0);
        wait_drained();
        // full exposure: saturated product and table end
        apb_write(etpw_pkg::REG_IMAGE_WIDTH, 32'd256);
        apb_write(etpw_pkg::REG_EXPOSURE_GAIN, 32'hFFFF);
        send_pixel(etpw_pkg::OP_DRAW, 8'd1, 8'd1, 16'd0, 16'd1, 16'hFFFF);
        send_pixel(etpw_pkg::OP_DRAW, 8'd2, 8'd1, 16'd16, 16'd256, 16'd4096);
        send_pixel(etpw_pkg::OP_READ, 8'd2, 8'd1, 16'd0, 16'd0, 16'd0);
        wait_drained();
        apb_write(etpw_pkg::REG_EXPOSURE_GAIN, 32'd1);
        send_pixel(etpw_pkg::OP_DRAW, 8'd3, 8'd1, 16'hFFFF, 16'h8000, 16'd1000);
        send_pixel(etpw_pkg::OP_READ, 8'd3, 8'd1, 16'd0, 16'd0, 16'd0);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            gain = phase_gain[ph];
            if (ph == 3)
                gain = 16'($urandom_range(512, 1));
            else if (ph == 6)
                gain = 16'($urandom_range(16'hFFFF, 1));
            apb_write(etpw_pkg::REG_IMAGE_WIDTH, 32'(phase_width[ph]));
            apb_write(etpw_pkg::REG_EXPOSURE_GAIN, 32'(gain));
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 36; stall_pct = 36; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 2 && i == PHASE_ITEMS / 2)
                    wait_drained();
                random_pixel();
            end
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
